[src/json_comment_lexer_macros.svh]
// Assertion macros used by the lexer checker.
`ifndef JSON_COMMENT_LEXER_MACROS_SVH
`define JSON_COMMENT_LEXER_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define JCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property that also holds across reset.
`define JCL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/jcl_pkg.sv]
package jcl_pkg;

  // Width of the position fields on the output stream
  localparam int PosW      = 24;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  localparam logic [7:0] ChLbrace   = 8'h7B;
  localparam logic [7:0] ChRbrace   = 8'h7D;
  localparam logic [7:0] ChLbracket = 8'h5B;
  localparam logic [7:0] ChRbracket = 8'h5D;
  localparam logic [7:0] ChColon    = 8'h3A;
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChSlash    = 8'h2F;
  localparam logic [7:0] ChStar     = 8'h2A;
  localparam logic [7:0] ChNewline  = 8'h0A;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChReturn   = 8'h0D;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChQuote    = 8'h22;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_WORD,
    MODE_SLASH,
    MODE_LINEC,
    MODE_BLOCK,
    MODE_STAR,
    MODE_ERROR
  } mode_e;

  typedef enum logic [2:0] {
    EV_PUNCT,
    EV_BEGIN,
    EV_VALUE,
    EV_END,
    EV_ERROR
  } ev_kind_e;

  typedef enum logic [2:0] {
    TK_LBRACE,
    TK_COMMA,
    TK_RBRACE,
    TK_LBRACKET,
    TK_RBRACKET,
    TK_COLON,
    TK_STRING,
    TK_WORD
  } tok_e;

  // One queue entry: the one or two events caused by a byte.
  // Both events of a pair share one position.
  typedef struct packed {
    logic             two;
    ev_kind_e         kind0;
    tok_e             tok0;
    ev_kind_e         kind1;
    tok_e             tok1;
    logic [7:0]       vbyte;
    logic [PosW-1:0]  line;
    logic [PosW-1:0]  col;
  } rec_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChReturn) || (c == ChNewline);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == ChLbrace) || (c == ChComma) || (c == ChRbrace) ||
           (c == ChLbracket) || (c == ChRbracket) || (c == ChColon);
  endfunction

  function automatic tok_e punct_tok(input logic [7:0] c);
    tok_e t;
    unique case (c)
      ChComma:    t = TK_COMMA;
      ChRbrace:   t = TK_RBRACE;
      ChLbracket: t = TK_LBRACKET;
      ChRbracket: t = TK_RBRACKET;
      ChColon:    t = TK_COLON;
      default:    t = TK_LBRACE;
    endcase
    return t;
  endfunction

endpackage

[src/jcl_front.sv]
module jcl_front #(
  parameter int POSITION_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  output logic             in_ready_o,
  input  logic             full_i,
  output logic             push_o,
  output jcl_pkg::rec_t    rec_o
);

  localparam int ExtW = (POSITION_BITS > jcl_pkg::PosW) ? POSITION_BITS : jcl_pkg::PosW;

  jcl_pkg::mode_e           mode_q, mode_d;
  logic [POSITION_BITS-1:0] line_q, line_d;
  logic [POSITION_BITS-1:0] col_q, col_d;
  logic                     accept;
  logic                     is_nl;
  logic [ExtW-1:0]          line_new_ext, col_new_ext, line_old_ext, col_old_ext;
  logic [1:0]               nev;
  logic                     use_old;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_nl      = (in_byte_i == jcl_pkg::ChNewline);

  // Counters after this byte; error mode freezes them
  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    if (mode_q != jcl_pkg::MODE_ERROR) begin
      if (is_nl) begin
        if (line_q != {POSITION_BITS{1'b1}}) line_d = line_q + POSITION_BITS'(1);
        col_d = '0;
      end else if (col_q != {POSITION_BITS{1'b1}}) begin
        col_d = col_q + POSITION_BITS'(1);
      end
    end
  end

  // Next mode
  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      jcl_pkg::MODE_IDLE: begin
        if (in_byte_i == jcl_pkg::ChQuote)                     mode_d = jcl_pkg::MODE_STRING;
        else if (in_byte_i == jcl_pkg::ChSlash)                mode_d = jcl_pkg::MODE_SLASH;
        else if (!jcl_pkg::is_space(in_byte_i) && !jcl_pkg::is_punct(in_byte_i))
          mode_d = jcl_pkg::MODE_WORD;
      end
      jcl_pkg::MODE_STRING: if (in_byte_i == jcl_pkg::ChQuote) mode_d = jcl_pkg::MODE_IDLE;
      jcl_pkg::MODE_WORD: begin
        if (jcl_pkg::is_space(in_byte_i) || jcl_pkg::is_punct(in_byte_i))
          mode_d = jcl_pkg::MODE_IDLE;
      end
      jcl_pkg::MODE_SLASH: begin
        if (in_byte_i == jcl_pkg::ChSlash)     mode_d = jcl_pkg::MODE_LINEC;
        else if (in_byte_i == jcl_pkg::ChStar) mode_d = jcl_pkg::MODE_BLOCK;
        else                                   mode_d = jcl_pkg::MODE_ERROR;
      end
      jcl_pkg::MODE_LINEC: if (is_nl) mode_d = jcl_pkg::MODE_IDLE;
      jcl_pkg::MODE_BLOCK: if (in_byte_i == jcl_pkg::ChStar) mode_d = jcl_pkg::MODE_STAR;
      jcl_pkg::MODE_STAR: begin
        if (in_byte_i == jcl_pkg::ChSlash)     mode_d = jcl_pkg::MODE_IDLE;
        else if (in_byte_i != jcl_pkg::ChStar) mode_d = jcl_pkg::MODE_BLOCK;
      end
      jcl_pkg::MODE_ERROR: mode_d = jcl_pkg::MODE_ERROR;
      default:             mode_d = jcl_pkg::MODE_ERROR;
    endcase
  end

  // Event decode
  always_comb begin
    nev        = 2'd0;
    use_old    = 1'b0;
    rec_o.two   = 1'b0;
    rec_o.kind0 = jcl_pkg::EV_PUNCT;
    rec_o.tok0  = jcl_pkg::TK_LBRACE;
    rec_o.kind1 = jcl_pkg::EV_PUNCT;
    rec_o.tok1  = jcl_pkg::TK_LBRACE;
    rec_o.vbyte = in_byte_i;
    unique case (mode_q)
      jcl_pkg::MODE_IDLE: begin
        if (jcl_pkg::is_punct(in_byte_i)) begin
          nev = 2'd1;
          rec_o.tok0 = jcl_pkg::punct_tok(in_byte_i);
        end else if (in_byte_i == jcl_pkg::ChQuote) begin
          nev = 2'd1;
          rec_o.kind0 = jcl_pkg::EV_BEGIN;
          rec_o.tok0  = jcl_pkg::TK_STRING;
        end else if (!jcl_pkg::is_space(in_byte_i) && in_byte_i != jcl_pkg::ChSlash) begin
          // first byte of a bare word: begin, then the byte itself
          nev = 2'd2;
          rec_o.kind0 = jcl_pkg::EV_BEGIN;
          rec_o.tok0  = jcl_pkg::TK_WORD;
          rec_o.kind1 = jcl_pkg::EV_VALUE;
          rec_o.tok1  = jcl_pkg::TK_WORD;
        end
      end
      jcl_pkg::MODE_STRING: begin
        nev = 2'd1;
        rec_o.tok0  = jcl_pkg::TK_STRING;
        rec_o.kind0 = (in_byte_i == jcl_pkg::ChQuote) ? jcl_pkg::EV_END : jcl_pkg::EV_VALUE;
      end
      jcl_pkg::MODE_WORD: begin
        rec_o.tok0 = jcl_pkg::TK_WORD;
        if (jcl_pkg::is_punct(in_byte_i)) begin
          // delimiter closes the word and is lexed again as punctuation
          nev = 2'd2;
          rec_o.kind0 = jcl_pkg::EV_END;
          rec_o.tok1  = jcl_pkg::punct_tok(in_byte_i);
        end else if (jcl_pkg::is_space(in_byte_i)) begin
          nev = 2'd1;
          rec_o.kind0 = jcl_pkg::EV_END;
        end else begin
          nev = 2'd1;
          rec_o.kind0 = jcl_pkg::EV_VALUE;
        end
      end
      jcl_pkg::MODE_SLASH: begin
        if (in_byte_i != jcl_pkg::ChSlash && in_byte_i != jcl_pkg::ChStar) begin
          nev = 2'd1;
          use_old = 1'b1;
          rec_o.kind0 = jcl_pkg::EV_ERROR;
        end
      end
      default: nev = 2'd0;
    endcase
    rec_o.two  = (nev == 2'd2);
    rec_o.line = use_old ? line_old_ext[jcl_pkg::PosW-1:0] : line_new_ext[jcl_pkg::PosW-1:0];
    rec_o.col  = use_old ? col_old_ext[jcl_pkg::PosW-1:0]  : col_new_ext[jcl_pkg::PosW-1:0];
  end

  assign line_new_ext = ExtW'(line_d);
  assign col_new_ext  = ExtW'(col_d);
  assign line_old_ext = ExtW'(line_q);
  assign col_old_ext  = ExtW'(col_q);

  assign push_o = accept && (nev != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jcl_pkg::MODE_IDLE;
      line_q <= POSITION_BITS'(1);
      col_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

endmodule

[src/jcl_queue.sv]
module jcl_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jcl_pkg::rec_t wdata_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output jcl_pkg::rec_t head_o
);

  jcl_pkg::rec_t                 mem_q [jcl_pkg::QueueDepth];
  logic [jcl_pkg::QueuePtrW-1:0] wptr_q, rptr_q;
  logic [jcl_pkg::QueuePtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (jcl_pkg::QueuePtrW+1)'(jcl_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i)      cnt_d = cnt_q + (jcl_pkg::QueuePtrW+1)'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - (jcl_pkg::QueuePtrW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wptr_q <= wptr_q + jcl_pkg::QueuePtrW'(1);
      if (pop_i)  rptr_q <= rptr_q + jcl_pkg::QueuePtrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

[src/jcl_back.sv]
module jcl_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  jcl_pkg::rec_t             head_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output jcl_pkg::ev_kind_e         kind_o,
  output jcl_pkg::tok_e             tok_o,
  output logic [7:0]                vbyte_o,
  output logic [jcl_pkg::PosW-1:0]  line_o,
  output logic [jcl_pkg::PosW-1:0]  col_o,
  output logic                      last_o
);

  // second event of a pair is being shown
  logic phase_q, phase_d;
  logic beat;

  assign valid_o = !empty_i;
  assign beat    = valid_o && ready_i;
  assign kind_o  = phase_q ? head_i.kind1 : head_i.kind0;
  assign tok_o   = phase_q ? head_i.tok1  : head_i.tok0;
  assign vbyte_o = (kind_o == jcl_pkg::EV_VALUE) ? head_i.vbyte : 8'd0;
  assign line_o  = head_i.line;
  assign col_o   = head_i.col;
  assign last_o  = phase_q || !head_i.two;
  assign pop_o   = beat && last_o;

  always_comb begin
    phase_d = phase_q;
    if (beat) phase_d = !last_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) phase_q <= 1'b0;
    else         phase_q <= phase_d;
  end

endmodule

[src/json_comment_lexer.sv]
// Streaming lexer for JSON text with // and /* */ comments.
// Slave stream: one text byte per beat in s_axis_tdata_i.
// Master stream: one event per beat. tuser carries event kind and token kind,
// tdata carries value byte, line and column; tlast marks the final event
// caused by an input byte (a byte causes zero, one or two events).
// Front end: mode register plus line/column counters, decodes each byte into
// a queue entry in the cycle it is taken. Back end: drains the 4-entry queue,
// one event per cycle while the receiver is ready; each entry is registered in the queue.
// Throughput: one byte per cycle while the queue has room; a byte that yields two
// events (word start, word end followed by punctuation) takes two output beats, which the
// queue absorbs; sustained rate is one event a cycle while m_axis_tready_i is high.
// Reset: mode idle, line 1, column 0, queue empty, nothing valid.
// When the receiver stalls, the current event holds and the queue fills;
// s_axis_tready_o drops only when all 4 entries are taken.
// After a malformed comment the error event is sent and every later byte is
// taken and dropped until reset.
module json_comment_lexer #(
  parameter int POSITION_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [7:0] value_byte, [31:8] line_number,
                                        // [55:32] column_number
  output logic [5:0]  m_axis_tuser_o,   // [2:0] event_kind, [5:3] token_kind
  output logic        m_axis_tlast_o    // last_of_step
);

  logic                     push, pop, full, empty;
  jcl_pkg::rec_t            wrec, head;
  jcl_pkg::ev_kind_e        kind;
  jcl_pkg::tok_e            tok;
  logic [7:0]               vbyte;
  logic [jcl_pkg::PosW-1:0] line, col;

  jcl_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_ready_o (s_axis_tready_o),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (wrec)
  );

  jcl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wrec),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  jcl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .kind_o  (kind),
    .tok_o   (tok),
    .vbyte_o (vbyte),
    .line_o  (line),
    .col_o   (col),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {col, line, vbyte};
  assign m_axis_tuser_o = {tok, kind};

endmodule

[src/jcl_checker.sv]
`include "json_comment_lexer_macros.svh"

module jcl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic [5:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic is_value, is_error, is_word_begin;

  assign is_value      = (m_axis_tuser_o[2:0] == jcl_pkg::EV_VALUE);
  assign is_error      = (m_axis_tuser_o[2:0] == jcl_pkg::EV_ERROR);
  assign is_word_begin = (m_axis_tuser_o[2:0] == jcl_pkg::EV_BEGIN) &&
                         (m_axis_tuser_o[5:3] == jcl_pkg::TK_WORD);

  `JCL_ASSERT(a_stall_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "output beat changed while stalled")
  `JCL_ASSERT(a_vbyte_zero, m_axis_tvalid_o && !is_value |-> m_axis_tdata_o[7:0] == 8'd0, "value byte set on non-value event")
  `JCL_ASSERT(a_error_form, m_axis_tvalid_o && is_error |-> m_axis_tlast_o && m_axis_tuser_o[5:3] == jcl_pkg::TK_LBRACE, "malformed error event")
  `JCL_ASSERT(a_word_pair, m_axis_tvalid_o && m_axis_tready_i && is_word_begin |=> m_axis_tvalid_o && m_axis_tuser_o[2:0] == jcl_pkg::EV_VALUE && m_axis_tlast_o, "word begin not followed by its first byte")
  `JCL_ASSERT_RST(a_reset_quiet, !rst_ni |=> !m_axis_tvalid_o, "output valid right after reset")

endmodule

bind json_comment_lexer jcl_checker u_jcl_checker (.*);
